/* hdl/csma_random_backoff_controller_defines.svh */
`ifndef CSMA_RANDOM_BACKOFF_CONTROLLER_DEFINES_SVH
`define CSMA_RANDOM_BACKOFF_CONTROLLER_DEFINES_SVH

// ante implies cons in the same cycle
`define CRBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define CRBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/crbc_pkg.sv */
package crbc_pkg;

	localparam int WORD_W    = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 4;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_INIT_WIN = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CONG_WIN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_BO   = 2'd2;

	localparam logic [WORD_W-1:0] INIT_WIN_RST = 16'd1024;
	localparam logic [WORD_W-1:0] CONG_WIN_RST = 16'd256;
	localparam logic [WORD_W-1:0] MIN_BO_RST   = 16'd32;
	localparam logic [WORD_W-1:0] RAND_STEP    = 16'd273;

	localparam logic [2:0] OP_SEND  = 3'd0;
	localparam logic [2:0] OP_ALARM = 3'd1;
	localparam logic [2:0] OP_DONE  = 3'd2;
	localparam logic [2:0] OP_FRAME = 3'd3;
	localparam logic [2:0] OP_READY = 3'd4;
	localparam logic [2:0] OP_SEED  = 3'd5;

	localparam logic [1:0] RES_OK   = 2'd0;
	localparam logic [1:0] RES_BUSY = 2'd1;

	typedef enum logic [1:0] {
		PH_READY,
		PH_FIRST,
		PH_SECOND,
		PH_SENDING
	} phase_t;

	typedef struct packed {
		logic [2:0]        op;
		logic              alarm_free;
		logic [WORD_W-1:0] now_time;
		logic [WORD_W-1:0] barrier_time;
		logic [1:0]        lower_result;
		logic [1:0]        finish_code;
		logic [WORD_W-1:0] seed_value;
	} in_word_t;

	typedef struct packed {
		logic              send_status;
		logic              alarm_start;
		logic [WORD_W-1:0] alarm_delay;
		logic              lower_try;
		logic              done_report;
		logic [1:0]        done_code;
		logic              ready_signal;
	} out_word_t;

	typedef struct packed {
		logic cap;
		logic div_start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_draw;
		logic div_busy;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

/* hdl/crbc_if.sv */
interface crbc_in_if;
	import crbc_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface crbc_out_if;
	import crbc_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/csma_random_backoff_controller.sv */
// After accept a word steps through S_EVAL and S_PUT to the output register; an event
// with a backoff draw also waits in S_DIV for the bit-serial modulus of the 16-bit
// random word by the backoff window. One word in flight; the next word is taken the
// cycle after its result enters the output register.
// Reset (arst_n low, asynchronous): phase ready, barrier clear, random word 0,
// windows and minimum backoff at their defaults, output register empty.
module csma_random_backoff_controller #(
	parameter int TIME_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	crbc_in_if.sink                     in_ch,
	crbc_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crbc_pkg::ADDR_W-1:0] paddr,
	input  logic [crbc_pkg::DATA_W-1:0] pwdata,
	output logic [crbc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import crbc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	crbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crbc_dp #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata)
	);

endmodule

/* hdl/crbc_mod.sv */
module crbc_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [crbc_pkg::WORD_W-1:0] num,
	input  logic [crbc_pkg::WORD_W-1:0] den,
	output logic                        busy,
	output logic                        done,
	output logic [crbc_pkg::WORD_W-1:0] rem
);
	import crbc_pkg::*;

	localparam int CNT_W = $clog2(WORD_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] den_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   sub;
	logic              ge;

	assign trial = {rem_q, num_q[WORD_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign sub   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(WORD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? sub[WORD_W-1:0] : trial[WORD_W-1:0];
			num_q <= {num_q[WORD_W-2:0], 1'b0};
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* hdl/crbc_dp.sv */
module crbc_dp #(
	parameter int TIME_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  crbc_pkg::in_word_t          in_data,
	input  crbc_pkg::cmd_t              cmd,
	output crbc_pkg::sts_t              sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output crbc_pkg::out_word_t         out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crbc_pkg::ADDR_W-1:0] paddr,
	input  logic [crbc_pkg::DATA_W-1:0] pwdata,
	output logic [crbc_pkg::DATA_W-1:0] prdata
);
	import crbc_pkg::*;

	localparam int EXT_W = (TIME_WIDTH > WORD_W) ? TIME_WIDTH : WORD_W;

	in_word_t          item_q;
	out_word_t         out_q;
	logic              out_valid_q;
	phase_t            phase_q;
	logic              flag_q;
	logic [WORD_W-1:0] bar_q;
	logic [WORD_W-1:0] rand_q;
	logic [WORD_W-1:0] init_win_q;
	logic [WORD_W-1:0] cong_win_q;
	logic [WORD_W-1:0] min_q;

	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  cfg_wr;
	logic [WORD_W-1:0]     diff_src;
	logic [EXT_W-1:0]      ext_diff;
	logic [TIME_WIDTH-1:0] tdiff;
	logic [EXT_W-1:0]      tdiff_ext;
	logic [WORD_W-1:0]     tdelay;
	logic                  ahead;
	logic                  idle;
	logic                  blocked;
	logic [1:0]            err;

	phase_t            nxt_phase;
	logic              nxt_flag;
	logic [WORD_W-1:0] nxt_bar;
	logic [WORD_W-1:0] nxt_rand;
	out_word_t         plan;
	out_word_t         res_word;
	logic              draw;
	logic              use_cong;

	logic [WORD_W-1:0] window;
	logic              div_busy;
	logic              div_done;
	logic [WORD_W-1:0] div_rem;
	logic [WORD_W-1:0] rem_eff;
	logic [WORD_W-1:0] draw_delay;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_win_q <= INIT_WIN_RST;
			cong_win_q <= CONG_WIN_RST;
			min_q      <= MIN_BO_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_INIT_WIN: init_win_q <= pwdata[WORD_W-1:0];
				REG_CONG_WIN: cong_win_q <= pwdata[WORD_W-1:0];
				REG_MIN_BO:   min_q      <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_INIT_WIN: prdata = DATA_W'(init_win_q);
			REG_CONG_WIN: prdata = DATA_W'(cong_win_q);
			REG_MIN_BO:   prdata = DATA_W'(min_q);
			default:      prdata = '0;
		endcase
	end

	// barrier distance, modulo the radio time width
	assign diff_src  = (item_q.op == OP_FRAME) ? item_q.barrier_time : bar_q;
	assign ext_diff  = EXT_W'(diff_src) - EXT_W'(item_q.now_time);
	assign tdiff     = ext_diff[TIME_WIDTH-1:0];
	assign tdiff_ext = EXT_W'(tdiff);
	assign tdelay    = tdiff_ext[WORD_W-1:0];
	assign ahead     = (tdiff != '0) && !tdiff[TIME_WIDTH-1];

	assign idle    = (phase_q == PH_READY) && !flag_q;
	assign blocked = flag_q && ahead;

	always_comb begin
		nxt_phase = phase_q;
		nxt_flag  = flag_q;
		nxt_bar   = bar_q;
		nxt_rand  = rand_q;
		plan      = '0;
		draw      = 1'b0;
		use_cong  = 1'b0;
		err       = RES_OK;
		case (item_q.op)
			OP_SEND: begin
				if (!idle || !item_q.alarm_free) begin
					plan.send_status = 1'b1;
				end else begin
					nxt_phase        = PH_FIRST;
					plan.alarm_start = 1'b1;
					draw             = 1'b1;
				end
			end
			OP_ALARM: begin
				if (idle) begin
				end else if (phase_q == PH_READY) begin
					nxt_flag          = 1'b0;
					plan.ready_signal = 1'b1;
				end else begin
					if (blocked) begin
						err = RES_BUSY;
					end else begin
						plan.lower_try = 1'b1;
						err            = item_q.lower_result;
					end
					if (err == RES_OK) begin
						nxt_phase = PH_SENDING;
						nxt_flag  = 1'b0;
					end else if (phase_q == PH_FIRST) begin
						nxt_phase        = PH_SECOND;
						plan.alarm_start = 1'b1;
						draw             = 1'b1;
						use_cong         = 1'b1;
					end else begin
						nxt_phase = PH_READY;
						if (blocked) begin
							nxt_flag         = 1'b1;
							plan.alarm_start = 1'b1;
							plan.alarm_delay = tdelay;
						end else begin
							nxt_flag = 1'b0;
						end
						plan.done_report = 1'b1;
						plan.done_code   = err;
					end
				end
			end
			OP_DONE: begin
				nxt_phase        = PH_READY;
				nxt_flag         = 1'b0;
				plan.done_report = 1'b1;
				plan.done_code   = item_q.finish_code;
			end
			OP_FRAME: begin
				nxt_bar = item_q.barrier_time;
				if (ahead) begin
					if (!idle) begin
						nxt_flag = 1'b1;
					end else if (item_q.alarm_free) begin
						nxt_flag         = 1'b1;
						plan.alarm_start = 1'b1;
						plan.alarm_delay = tdelay;
					end
				end
			end
			OP_READY: begin
				plan.ready_signal = idle && item_q.alarm_free;
			end
			OP_SEED: begin
				nxt_rand = item_q.seed_value;
			end
			default: ;
		endcase
	end

	assign window = use_cong ? cong_win_q : init_win_q;

	crbc_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (rand_q),
		.den    (window),
		.busy   (div_busy),
		.done   (div_done),
		.rem    (div_rem)
	);

	assign rem_eff    = (window == '0) ? '0 : div_rem;
	assign draw_delay = rem_eff + min_q;

	always_comb begin
		res_word = plan;
		if (draw) begin
			res_word.alarm_delay = draw_delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_READY;
			flag_q      <= 1'b0;
			bar_q       <= '0;
			rand_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				phase_q     <= nxt_phase;
				flag_q      <= nxt_flag;
				bar_q       <= nxt_bar;
				rand_q      <= draw ? rand_q + RAND_STEP : nxt_rand;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= in_data;
		end
		if (cmd.commit) begin
			out_q <= res_word;
		end
	end

	assign sts.need_draw = draw;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/crbc_ctrl.sv */
`include "csma_random_backoff_controller_defines.svh"

module crbc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  crbc_pkg::sts_t sts,
	output crbc_pkg::cmd_t cmd
);
	import crbc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_PUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign cmd.cap       = in_valid && in_ready_q;
	assign cmd.div_start = (state_q == S_EVAL) && sts.need_draw;
	assign cmd.commit    = (state_q == S_PUT) && sts.out_free;
	assign in_ready      = in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.cap) begin
						state_q    <= S_EVAL;
						in_ready_q <= 1'b0;
					end
				end
				S_EVAL: begin
					state_q <= sts.need_draw ? S_DIV : S_PUT;
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (sts.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	`CRBC_ASSERT_NXT(a_cap_drops_ready, cmd.cap, !in_ready_q, "ready stayed high after accept")
	`CRBC_ASSERT_NXT(a_div_no_commit, cmd.div_start, !cmd.commit, "commit before modulus done")
	`CRBC_ASSERT_IMP(a_ready_div_idle, in_ready_q, !sts.div_busy, "ready while modulus runs")
	`CRBC_ASSERT_IMP(a_done_in_div, sts.div_done, state_q == S_DIV, "modulus done outside wait")

endmodule

/* bench/tb_csma_random_backoff_controller.sv */
`timescale 1ns / 1ps

module tb_csma_random_backoff_controller;
	import crbc_pkg::*;

	localparam int TIME_W         = 16;
	localparam int N_SETS         = 8;
	localparam int EVENTS_PER_SET = 212;
	localparam int SETTLE_CYCLES  = 25;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int HOLD_AFTER     = 600;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t res;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	crbc_in_if  in_ch ();
	crbc_out_if out_ch ();

	csma_random_backoff_controller #(.TIME_WIDTH(TIME_W)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [15:0] win_first;
	logic [15:0] win_retry;
	logic [15:0] backoff_floor;
	phase_t      mac_phase;
	logic        barrier_up;
	logic [15:0] barrier_mark;
	logic [15:0] rand_word;

	out_word_t awaited_answers[$];
	dir_row_t  dir_rows[$];
	int        n_events;
	int        n_directed;
	int        n_answers;
	int        n_mismatch;
	int        n_settings;
	bit        no_gaps;

	function automatic logic [15:0] draw_backoff(logic [15:0] win);
		logic [15:0] cur;
		logic [15:0] rem;
		cur = rand_word;
		rand_word = rand_word + RAND_STEP;
		rem = (win == 16'd0) ? 16'd0 : cur % win;
		return rem + backoff_floor;
	endfunction

	function automatic out_word_t predict_mac_answer(in_word_t w);
		out_word_t   o;
		logic        idle;
		logic        ahead;
		logic [15:0] diff;
		logic [1:0]  fail_code;
		o = '0;
		idle = (mac_phase == PH_READY) && !barrier_up;
		case (w.op)
			OP_SEND: begin
				if (!idle || !w.alarm_free) begin
					o.send_status = 1'b1;
				end else begin
					mac_phase = PH_FIRST;
					o.alarm_start = 1'b1;
					o.alarm_delay = draw_backoff(win_first);
				end
			end
			OP_ALARM: begin
				if (idle) begin
				end else if (mac_phase == PH_READY) begin
					barrier_up = 1'b0;
					o.ready_signal = 1'b1;
				end else begin
					diff = barrier_mark - w.now_time;
					ahead = (diff != 16'd0) && !diff[TIME_W-1];
					if (barrier_up && ahead) begin
						fail_code = RES_BUSY;
					end else begin
						o.lower_try = 1'b1;
						fail_code = w.lower_result;
					end
					if (fail_code == RES_OK) begin
						mac_phase = PH_SENDING;
						barrier_up = 1'b0;
					end else if (mac_phase == PH_FIRST) begin
						mac_phase = PH_SECOND;
						o.alarm_start = 1'b1;
						o.alarm_delay = draw_backoff(win_retry);
					end else begin
						if (barrier_up && ahead) begin
							o.alarm_start = 1'b1;
							o.alarm_delay = diff;
						end else begin
							barrier_up = 1'b0;
						end
						mac_phase = PH_READY;
						o.done_report = 1'b1;
						o.done_code = fail_code;
					end
				end
			end
			OP_DONE: begin
				mac_phase = PH_READY;
				barrier_up = 1'b0;
				o.done_report = 1'b1;
				o.done_code = w.finish_code;
			end
			OP_FRAME: begin
				barrier_mark = w.barrier_time;
				diff = w.barrier_time - w.now_time;
				if ((diff != 16'd0) && !diff[TIME_W-1]) begin
					if (!idle) begin
						barrier_up = 1'b1;
					end else if (w.alarm_free) begin
						o.alarm_start = 1'b1;
						o.alarm_delay = diff;
						barrier_up = 1'b1;
					end
				end
			end
			OP_READY: begin
				if (idle && w.alarm_free)
					o.ready_signal = 1'b1;
			end
			OP_SEED: begin
				rand_word = w.seed_value;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_word_t mk_in(logic [2:0] op, logic af, logic [15:0] now,
			logic [15:0] bar, logic [1:0] lres, logic [1:0] fin, logic [15:0] seed);
		in_word_t w;
		w.op = op;
		w.alarm_free = af;
		w.now_time = now;
		w.barrier_time = bar;
		w.lower_result = lres;
		w.finish_code = fin;
		w.seed_value = seed;
		return w;
	endfunction

	function automatic out_word_t mk_out(logic ss, logic as, logic [15:0] dly, logic lt,
			logic dr, logic [1:0] dc, logic rs);
		out_word_t o;
		o.send_status = ss;
		o.alarm_start = as;
		o.alarm_delay = dly;
		o.lower_try = lt;
		o.done_report = dr;
		o.done_code = dc;
		o.ready_signal = rs;
		return o;
	endfunction

	function automatic void add_row(in_word_t w, bit typed, out_word_t res);
		dir_row_t row;
		row.w = w;
		row.typed = typed;
		row.res = res;
		dir_rows.push_back(row);
	endfunction

	function automatic in_word_t gen_event();
		in_word_t    w;
		int          r;
		logic [15:0] delta;
		w = '0;
		w.alarm_free = ($urandom_range(0, 9) != 0);
		w.now_time = 16'($urandom);
		w.barrier_time = 16'($urandom);
		w.finish_code = 2'($urandom);
		w.seed_value = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 60)
			w.lower_result = RES_OK;
		else if (r < 80)
			w.lower_result = RES_BUSY;
		else
			w.lower_result = 2'($urandom_range(2, 3));
		r = $urandom_range(0, 99);
		if (r < 12) begin
			w.op = 3'($urandom_range(0, 7));
			return w;
		end
		r = $urandom_range(0, 99);
		if ((mac_phase == PH_READY) && !barrier_up) begin
			if (r < 55)
				w.op = OP_SEND;
			else if (r < 70)
				w.op = OP_FRAME;
			else if (r < 80)
				w.op = OP_READY;
			else if (r < 88)
				w.op = OP_SEED;
			else if (r < 94)
				w.op = OP_ALARM;
			else
				w.op = OP_DONE;
		end else begin
			if ((mac_phase == PH_SENDING) && (r < 40))
				w.op = OP_DONE;
			else if (r < 70)
				w.op = OP_ALARM;
			else if (r < 80)
				w.op = OP_FRAME;
			else if (r < 86)
				w.op = OP_DONE;
			else if (r < 92)
				w.op = OP_SEND;
			else if (r < 96)
				w.op = OP_READY;
			else
				w.op = OP_SEED;
		end
		r = $urandom_range(0, 99);
		if (w.op == OP_FRAME) begin
			if (r < 65) begin
				delta = 16'($urandom_range(0, 3000));
				w.barrier_time = w.now_time + delta;
			end else if (r < 85) begin
				delta = 16'($urandom_range(0, 300));
				w.barrier_time = w.now_time - delta;
			end
		end else if ((w.op == OP_ALARM) && barrier_up) begin
			if (r < 60) begin
				delta = 16'($urandom_range(0, 300));
				w.now_time = barrier_mark - delta;
			end else if (r < 80) begin
				delta = 16'($urandom_range(0, 300));
				w.now_time = barrier_mark + delta;
			end
		end
		return w;
	endfunction

	task automatic offer_word(in_word_t w, bit typed, out_word_t res);
		out_word_t pred;
		int        gap;
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		pred = predict_mac_answer(w);
		awaited_answers.push_back(typed ? res : pred);
		n_events++;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
		logic [15:0] junk;
		junk = 16'($urandom);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {junk, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_INIT_WIN: win_first = val;
			REG_CONG_WIN: win_retry = val;
			REG_MIN_BO:   backoff_floor = val;
			default: begin
			end
		endcase
	endtask

	task automatic check_answer(out_word_t got);
		out_word_t want;
		bit        bad;
		n_answers++;
		if (awaited_answers.size() == 0) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("%0t: unexpected word %h", $time, got);
			return;
		end
		want = awaited_answers.pop_front();
		bad = (got.send_status !== want.send_status) ||
			(got.alarm_start !== want.alarm_start) ||
			(got.alarm_delay !== want.alarm_delay) ||
			(got.lower_try !== want.lower_try) ||
			(got.done_report !== want.done_report) ||
			(got.done_code !== want.done_code) ||
			(got.ready_signal !== want.ready_signal);
		if (bad) begin
			n_mismatch++;
			if (n_mismatch <= 10) begin
				$display("%0t: word %0d expected ss=%b as=%b dly=%h lt=%b dr=%b dc=%0d rs=%b",
					$time, n_answers, want.send_status, want.alarm_start, want.alarm_delay,
					want.lower_try, want.done_report, want.done_code, want.ready_signal);
				$display("%0t: word %0d actual   ss=%b as=%b dly=%h lt=%b dr=%b dc=%0d rs=%b",
					$time, n_answers, got.send_status, got.alarm_start, got.alarm_delay,
					got.lower_try, got.done_report, got.done_code, got.ready_signal);
			end
		end
	endtask

	initial begin
		int          stall_left;
		bit          long_hold_done;
		stall_left = 0;
		long_hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				check_answer(out_ch.data);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!long_hold_done && (n_answers >= HOLD_AFTER)) begin
					long_hold_done = 1'b1;
					stall_left = LONG_HOLD;
				end else begin
					stall_left = pick_gap();
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [15:0] v_first;
		logic [15:0] v_retry;
		logic [15:0] v_floor;
		n_events = 0;
		n_directed = 0;
		n_answers = 0;
		n_mismatch = 0;
		n_settings = 0;
		no_gaps = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		win_first = INIT_WIN_RST;
		win_retry = CONG_WIN_RST;
		backoff_floor = MIN_BO_RST;
		mac_phase = PH_READY;
		barrier_up = 1'b0;
		barrier_mark = '0;
		rand_word = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(mk_in(OP_READY, 1, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 1));
		add_row(mk_in(OP_READY, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 0));
		add_row(mk_in(OP_ALARM, 1, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 0));
		add_row(mk_in(OP_SPARE_A, 1, 16'hFFFF, 16'hFFFF, 3, 3, 16'hFFFF), 1, '0);
		add_row(mk_in(OP_SPARE_B, 1, 16'hFFFF, 16'hFFFF, 3, 3, 16'hFFFF), 1, '0);
		add_row(mk_in(OP_SEND, 0, 0, 0, 0, 0, 0), 1, mk_out(1, 0, 0, 0, 0, 0, 0));
		add_row(mk_in(OP_SEND, 1, 0, 0, 0, 0, 0), 1, mk_out(0, 1, 16'd32, 0, 0, 0, 0));
		add_row(mk_in(OP_SEND, 1, 0, 0, 0, 0, 0), 1, mk_out(1, 0, 0, 0, 0, 0, 0));
		add_row(mk_in(OP_ALARM, 1, 0, 0, RES_BUSY, 0, 0), 0, '0);
		add_row(mk_in(OP_ALARM, 1, 0, 0, 2, 0, 0), 1, mk_out(0, 0, 0, 1, 1, 2, 0));
		add_row(mk_in(OP_SEED, 1, 0, 0, 0, 0, 16'hFFFF), 1, '0);
		add_row(mk_in(OP_SEND, 1, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk_in(OP_ALARM, 1, 0, 0, RES_OK, 0, 0), 1, mk_out(0, 0, 0, 1, 0, 0, 0));
		add_row(mk_in(OP_ALARM, 1, 16'hFFFF, 0, 3, 0, 0), 1, mk_out(0, 0, 0, 1, 1, 3, 0));
		add_row(mk_in(OP_FRAME, 1, 0, 16'hFFFF, 0, 0, 0), 1, '0);
		add_row(mk_in(OP_FRAME, 1, 0, 16'h7FFF, 0, 0, 0), 1,
			mk_out(0, 1, 16'h7FFF, 0, 0, 0, 0));
		add_row(mk_in(OP_SEND, 1, 0, 0, 0, 0, 0), 1, mk_out(1, 0, 0, 0, 0, 0, 0));
		add_row(mk_in(OP_ALARM, 1, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 1));
		add_row(mk_in(OP_FRAME, 0, 16'hFFFF, 16'h0010, 0, 0, 0), 1, '0);
		add_row(mk_in(OP_SEND, 1, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk_in(OP_FRAME, 0, 16'h1000, 16'h1010, 0, 0, 0), 1, '0);
		add_row(mk_in(OP_ALARM, 1, 16'h1000, 0, RES_OK, 0, 0), 0, '0);
		add_row(mk_in(OP_ALARM, 1, 16'h1008, 0, RES_OK, 0, 0), 1,
			mk_out(0, 1, 16'd8, 0, 1, RES_BUSY, 0));
		add_row(mk_in(OP_ALARM, 1, 0, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 1));
		add_row(mk_in(OP_SEND, 1, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk_in(OP_DONE, 1, 0, 0, 0, 3, 0), 1, mk_out(0, 0, 0, 0, 1, 3, 0));

		foreach (dir_rows[i])
			offer_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
		n_directed = n_events;
		in_ch.valid <= 1'b0;

		for (int p = 0; p < N_SETS; p++) begin
			wait_idle();
			case (p)
				0: begin v_first = 16'd0;    v_retry = 16'd0;    v_floor = 16'd0;    end
				1: begin v_first = 16'hFFFF; v_retry = 16'hFFFF; v_floor = 16'hFFFF; end
				2: begin v_first = 16'd1;    v_retry = 16'd1;    v_floor = 16'd0;    end
				3: begin v_first = 16'hFFFF; v_retry = 16'd0;    v_floor = 16'hFFF0; end
				4: begin v_first = 16'd0;    v_retry = 16'hFFFF; v_floor = 16'd1;    end
				default: begin
					v_first = 16'($urandom_range(1, 64));
					v_retry = 16'($urandom);
					v_floor = 16'($urandom);
				end
			endcase
			reg_write(REG_INIT_WIN, v_first);
			reg_write(REG_CONG_WIN, v_retry);
			reg_write(REG_MIN_BO, v_floor);
			n_settings++;
			no_gaps = (p == 2);
			repeat (EVENTS_PER_SET)
				offer_word(gen_event(), 1'b0, '0);
			in_ch.valid <= 1'b0;
		end
		no_gaps = 1'b0;

		wait_idle();
		$display("covered %0d event words (%0d directed) over %0d register settings",
			n_events, n_directed, n_settings);
		$display("checked %0d result words, %0d mismatches", n_answers, n_mismatch);
		if (n_mismatch == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
